// ===== sv/kscan_pkg.sv =====
// Shared types, constants and key map for the keypad scan decoder.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package kscan_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ROWS            = 4;
    localparam int COLS            = 4;
    localparam int CODE_W          = 7;
    localparam int MATRIX_W        = ROWS * COLS;
    localparam int PRESS_W         = 5;

    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CODE_W-1:0] NO_KEY = '0;

    // ASCII codes in scan order, bit row*4+col
    localparam logic [CODE_W-1:0] KEY_TABLE [MATRIX_W] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    typedef struct packed {
        logic       hit;
        logic [1:0] col;
        logic [2:0] count;
    } t_lane_res;

    typedef struct packed {
        logic [PRESS_W-1:0] count;
        logic [CODE_W-1:0]  code;
    } t_scan;

endpackage

`default_nettype wire

// ===== sv/kscan_lane.sv =====
// One row lane: counts pressed keys in a 4-bit active-low row sample
// and finds the last pressed column. Uses kscan_pkg.
`default_nettype none

module kscan_lane (
    input  wire logic [3:0]          i_row_n,
    output kscan_pkg::t_lane_res     o_res
);

    logic [3:0] down;

    always_comb begin
        down        = ~i_row_n;
        o_res.hit   = |down;
        o_res.count = {2'b00, down[0]} + {2'b00, down[1]}
                    + {2'b00, down[2]} + {2'b00, down[3]};
        if (down[3]) begin
            o_res.col = 2'd3;
        end else if (down[2]) begin
            o_res.col = 2'd2;
        end else if (down[1]) begin
            o_res.col = 2'd1;
        end else begin
            o_res.col = 2'd0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kscan_merge.sv =====
// Merge of the four row lanes: total key count and ASCII code of the
// last pressed key in scan order. Uses kscan_pkg.
`default_nettype none

module kscan_merge (
    input  wire kscan_pkg::t_lane_res i_lane [kscan_pkg::ROWS],
    output kscan_pkg::t_scan         o_scan
);

    logic [1:0] row;
    logic [1:0] col;
    logic       any;

    always_comb begin
        o_scan.count = {2'b00, i_lane[0].count} + {2'b00, i_lane[1].count}
                     + {2'b00, i_lane[2].count} + {2'b00, i_lane[3].count};
        any = i_lane[0].hit | i_lane[1].hit | i_lane[2].hit | i_lane[3].hit;
        if (i_lane[3].hit) begin
            row = 2'd3;
            col = i_lane[3].col;
        end else if (i_lane[2].hit) begin
            row = 2'd2;
            col = i_lane[2].col;
        end else if (i_lane[1].hit) begin
            row = 2'd1;
            col = i_lane[1].col;
        end else begin
            row = 2'd0;
            col = i_lane[0].col;
        end
        o_scan.code = any ? kscan_pkg::KEY_TABLE[{row, col}] : kscan_pkg::NO_KEY;
    end

endmodule

`default_nettype wire

// ===== sv/kscan_queue.sv =====
// Key queue with remembered-key filter and result register.
// Holds the queue memory, pointers, level and output stage. Uses kscan_pkg.
`default_nettype none

module kscan_queue #(
    parameter int QUEUE_DEPTH = kscan_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_kind,
    input  wire kscan_pkg::t_scan                i_scan,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [kscan_pkg::CODE_W-1:0]         o_key_code,
    output logic                                 o_key_valid,
    output logic [kscan_pkg::PRESS_W-1:0]        o_keys_pressed,
    output logic                                 o_key_queued,
    output logic                                 o_key_dropped,
    output logic [CNT_W-1:0]                     o_queue_level
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [kscan_pkg::CODE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]             r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]             r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [kscan_pkg::CODE_W-1:0] r_last, n_last;
    logic                         r_out_valid;
    logic [kscan_pkg::CODE_W-1:0] r_key_code;
    logic                         r_key_valid;
    logic [kscan_pkg::PRESS_W-1:0] r_keys_pressed;
    logic                         r_key_queued;
    logic                         r_key_dropped;
    logic [CNT_W-1:0]             r_queue_level;

    logic is_poll, new_key, push, pop, drop;

    always_comb begin
        is_poll  = (i_kind == kscan_pkg::KIND_POLL);
        new_key  = is_poll && (i_scan.count == kscan_pkg::PRESS_W'(1))
                   && (i_scan.code != r_last);
        push     = new_key && (r_count != CNT_FULL);
        drop     = new_key && (r_count == CNT_FULL);
        pop      = !is_poll && (r_count != '0);
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_last   = r_last;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            n_count  = r_count + CNT_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            n_count  = r_count - CNT_W'(1);
        end
        if (new_key) begin
            n_last = i_scan.code;
        end else if (is_poll && (i_scan.count == '0)) begin
            n_last = kscan_pkg::NO_KEY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_last      <= kscan_pkg::NO_KEY;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_count     <= n_count;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && push) begin
            r_mem[r_wr_ptr] <= i_scan.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (is_poll) begin
                r_key_code <= i_scan.code;
            end else if (pop) begin
                r_key_code <= r_mem[r_rd_ptr];
            end else begin
                r_key_code <= kscan_pkg::NO_KEY;
            end
            r_key_valid    <= pop;
            r_keys_pressed <= is_poll ? i_scan.count : '0;
            r_key_queued   <= push;
            r_key_dropped  <= drop;
            r_queue_level  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_code     = r_key_code;
    assign o_key_valid    = r_key_valid;
    assign o_keys_pressed = r_keys_pressed;
    assign o_key_queued   = r_key_queued;
    assign o_key_dropped  = r_key_dropped;
    assign o_queue_level  = r_queue_level;

endmodule

`default_nettype wire

// ===== sv/keypad_scan_decoder_top.sv =====
// Top level of the keypad scan decoder: four row lanes, merge, key queue.
// Depends on kscan_pkg, kscan_lane, kscan_merge and kscan_queue.
//
// Each request is either a poll carrying a full 4x4 active-low keypad sample
// or a read that pops one key code from the queue. The block takes one
// request per clock while the output is not stalled and returns its result
// in the cycle after acceptance from a single output register; the queue
// memory is written and read once per cycle, so polls and reads may be
// freely interleaved at full rate. A new request is taken in the same cycle
// the pending result is taken. Queue contents need no clearing after reset.
`default_nettype none

module keypad_scan_decoder_top #(
    parameter int QUEUE_DEPTH = kscan_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_kind,
    input  wire logic [kscan_pkg::MATRIX_W-1:0]   i_key_matrix,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [kscan_pkg::CODE_W-1:0]          o_key_code,
    output logic                                  o_key_valid,
    output logic [kscan_pkg::PRESS_W-1:0]         o_keys_pressed,
    output logic                                  o_key_queued,
    output logic                                  o_key_dropped,
    output logic [CNT_W-1:0]                      o_queue_level
);

    kscan_pkg::t_lane_res lane_res [kscan_pkg::ROWS];
    kscan_pkg::t_scan     scan;
    logic                 accept;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    for (genvar g = 0; g < kscan_pkg::ROWS; g++) begin : g_lane
        kscan_lane u_lane (
            .i_row_n (i_key_matrix[g*kscan_pkg::COLS +: kscan_pkg::COLS]),
            .o_res   (lane_res[g])
        );
    end

    kscan_merge u_merge (
        .i_lane (lane_res),
        .o_scan (scan)
    );

    kscan_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_scan         (scan),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_key_code     (o_key_code),
        .o_key_valid    (o_key_valid),
        .o_keys_pressed (o_keys_pressed),
        .o_key_queued   (o_key_queued),
        .o_key_dropped  (o_key_dropped),
        .o_queue_level  (o_queue_level)
    );

endmodule

`default_nettype wire
